// ===== sv/ctb_pkg.sv =====
// shared types, codes and helpers for the countdown timer bank
// used by ctb_cell and countdown_timer_bank; no dependencies
package ctb_pkg;

  localparam int NUM_TIMERS_DEF = 8;
  localparam int PERIOD_W       = 32;
  localparam int ID_W           = 3;
  localparam int MASK_W         = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int IDX_W          = 6;   // wide enough for any timer index up to 32

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  localparam logic [1:0] KIND_STARTED = 2'd0;
  localparam logic [1:0] KIND_EXPIRED = 2'd1;
  localparam logic [1:0] KIND_STOPPED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_EN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE_EN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_EN    = 2'd3;

  typedef struct packed {
    logic [PERIOD_W-1:0] reload;
    logic [PERIOD_W-1:0] remain;
  } entry_t;

  // mask bits only exist for the first eight timers
  function automatic logic mask_bit(logic [MASK_W-1:0] mask, logic [IDX_W-1:0] idx);
    logic res;
    res = 1'b0;
    if (idx < IDX_W'(MASK_W)) begin
      res = mask[idx[2:0]];
    end
    return res;
  endfunction

endpackage

// ===== sv/ctb_cell.sv =====
// one timer slot of the rotating ring: reload value and countdown
// depends on ctb_pkg
module ctb_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift,
  input  ctb_pkg::entry_t shift_in,
  input  logic            load,
  input  ctb_pkg::entry_t load_val,
  output ctb_pkg::entry_t ent
);

  ctb_pkg::entry_t ent_r;
  ctb_pkg::entry_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    if (load) begin
      ent_nxt = load_val;
    end else if (shift) begin
      ent_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent = ent_r;

endmodule

// ===== sv/countdown_timer_bank.sv =====
// countdown_timer_bank: a bank of NUM_TIMERS countdown timers, a rotating ring of cells
// depends on ctb_pkg and ctb_cell
//
// A start or stop request leaves busy low; its started or stopped event, if enabled,
// shows on the out_ ports in the cycle after the request. A tick request rotates the
// ring of timer cells once, one timer per cycle through a single decrement unit at the
// head, with busy high throughout. Expired events come out in ascending timer order, at
// most one per cycle; each is held back until the next expiring timer passes the head,
// so the final one, flagged by out_last, appears in the same cycle that busy falls.
// out_valid is a one-cycle strobe and the receiver must take every event as it comes.
// Configuration must be written with cfg_we only while the bank is idle; the bank
// itself does not enforce this.
module countdown_timer_bank #(
  parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_action,
  input  logic [ctb_pkg::ID_W-1:0]       in_timer_id,
  input  logic [ctb_pkg::PERIOD_W-1:0]   in_period,
  output logic                           out_valid,
  output logic [1:0]                     out_event_kind,
  output logic [ctb_pkg::ID_W-1:0]       out_event_timer,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [ctb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctb_pkg::MASK_W-1:0]     cfg_wdata
);

  localparam int CW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_END} state_t;

  state_t                       state_r, state_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic                         hold_valid_r, hold_valid_nxt;
  logic [ctb_pkg::ID_W-1:0]     hold_timer_r, hold_timer_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   out_kind_r, out_kind_nxt;
  logic [ctb_pkg::ID_W-1:0]     out_timer_r, out_timer_nxt;
  logic                         out_last_r, out_last_nxt;
  logic [ctb_pkg::MASK_W-1:0]   periodic_r, start_en_r, expire_en_r, stop_en_r;

  ctb_pkg::entry_t              ent [NUM_TIMERS];
  ctb_pkg::entry_t              head_nxt;
  ctb_pkg::entry_t              load_val;
  logic                         accept;
  logic                         id_ok;
  logic                         do_load;
  logic                         shift;
  logic                         head_expire;
  logic                         head_event;
  logic [ctb_pkg::IDX_W-1:0]    head_idx;
  logic [ctb_pkg::IDX_W-1:0]    req_idx;

  assign accept   = start && (state_r == ST_IDLE);
  assign id_ok    = 32'(in_timer_id) < NUM_TIMERS;
  assign do_load  = accept && id_ok &&
                    (in_action == ctb_pkg::ACT_STOP ||
                     (in_action == ctb_pkg::ACT_START && in_period != '0));
  assign load_val = (in_action == ctb_pkg::ACT_START)
                    ? ctb_pkg::entry_t'{reload: in_period, remain: in_period}
                    : ctb_pkg::entry_t'('0);
  assign shift    = (state_r == ST_WALK);
  assign head_idx = ctb_pkg::IDX_W'(cnt_r);
  assign req_idx  = ctb_pkg::IDX_W'(in_timer_id);

  // head of the ring: decrement, expire and, for periodic timers, reload
  always_comb begin
    head_nxt    = ent[0];
    head_expire = (ent[0].remain == ctb_pkg::PERIOD_W'(1));
    if (head_expire) begin
      head_nxt.remain = ctb_pkg::mask_bit(periodic_r, head_idx) ? ent[0].reload : '0;
    end else if (ent[0].remain != '0) begin
      head_nxt.remain = ent[0].remain - ctb_pkg::PERIOD_W'(1);
    end
    head_event = head_expire && ctb_pkg::mask_bit(expire_en_r, head_idx);
  end

  for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
    ctb_pkg::entry_t sin;
    if (k == NUM_TIMERS - 1) begin : g_tail
      assign sin = head_nxt;
    end else begin : g_mid
      assign sin = ent[k+1];
    end
    ctb_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (shift),
      .shift_in (sin),
      .load     (do_load && (32'(in_timer_id) == k)),
      .load_val (load_val),
      .ent      (ent[k])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    hold_valid_nxt = hold_valid_r;
    hold_timer_nxt = hold_timer_r;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_timer_nxt  = out_timer_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            ctb_pkg::ACT_TICK: begin
              state_nxt      = ST_WALK;
              cnt_nxt        = '0;
              hold_valid_nxt = 1'b0;
            end
            ctb_pkg::ACT_START: begin
              if (id_ok && in_period != '0 && ctb_pkg::mask_bit(start_en_r, req_idx)) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = ctb_pkg::KIND_STARTED;
                out_timer_nxt = in_timer_id;
                out_last_nxt  = 1'b1;
              end
            end
            ctb_pkg::ACT_STOP: begin
              if (id_ok && ctb_pkg::mask_bit(stop_en_r, req_idx)) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = ctb_pkg::KIND_STOPPED;
                out_timer_nxt = in_timer_id;
                out_last_nxt  = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        // an event is held back until the next one arrives so the final one can carry last
        if (head_event) begin
          if (hold_valid_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = ctb_pkg::KIND_EXPIRED;
            out_timer_nxt = hold_timer_r;
            out_last_nxt  = 1'b0;
          end
          hold_valid_nxt = 1'b1;
          hold_timer_nxt = ctb_pkg::ID_W'(cnt_r);
        end
        if (cnt_r == CW'(NUM_TIMERS - 1)) begin
          state_nxt = ST_END;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_END: begin
        if (hold_valid_r) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = ctb_pkg::KIND_EXPIRED;
          out_timer_nxt = hold_timer_r;
          out_last_nxt  = 1'b1;
        end
        hold_valid_nxt = 1'b0;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    hold_timer_r <= hold_timer_nxt;
    out_kind_r   <= out_kind_nxt;
    out_timer_r  <= out_timer_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      periodic_r  <= '0;
      start_en_r  <= '0;
      expire_en_r <= '0;
      stop_en_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ctb_pkg::CFG_PERIODIC:  periodic_r  <= cfg_wdata;
        ctb_pkg::CFG_START_EN:  start_en_r  <= cfg_wdata;
        ctb_pkg::CFG_EXPIRE_EN: expire_en_r <= cfg_wdata;
        ctb_pkg::CFG_STOP_EN:   stop_en_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_event_kind  = out_kind_r;
  assign out_event_timer = out_timer_r;
  assign out_last        = out_last_r;

endmodule
